// ===== src/gse_pkg.sv =====
// ---------------------------------------------------------------------------
// Grid successor expander package
// Shared types, widths and small helpers for the 3D successor expander.
// ---------------------------------------------------------------------------
package gse_pkg;

  localparam int unsigned GRID_SIDE_DEF = 64;
  localparam int unsigned NUM_MOVES_DEF = 6;

  localparam int unsigned NUM_SLOTS   = 6;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned SCOORD_W    = 8;
  localparam int unsigned DIST_W      = 9;
  localparam int unsigned ID_W        = 18;
  localparam int unsigned NEXT_ID_W   = 19;
  localparam int unsigned COST_W      = 16;
  localparam int unsigned MOVE_W      = 23;
  localparam int unsigned DIMS_W      = 21;
  localparam int unsigned DIM_W       = 7;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 21'd1056832;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 3'd6;

  // Fields of a move register.
  localparam int unsigned MV_COST_LO = 6;
  localparam int unsigned MV_EN_BIT  = 22;

  localparam logic [1:0] OFF_PLUS  = 2'd1;
  localparam logic [1:0] OFF_MINUS = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WRITE,
    OP_EXPAND
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [COORD_W-1:0]      cx;
    logic [COORD_W-1:0]      cy;
    logic [COORD_W-1:0]      cz;
    logic                    occ;
    logic [NUM_SLOTS-1:0]    mask;
    logic [COORD_W-1:0]      ax;
    logic [COORD_W-1:0]      ay;
    logic [COORD_W-1:0]      az;
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    logic [COORD_W-1:0]      pz;
  } cmd_t;

  typedef logic [MOVE_W-1:0] move_t;

  function automatic logic [SCOORD_W-1:0] offset_of(input logic [1:0] code);
    logic [SCOORD_W-1:0] r;
    r = '0;
    if (code == OFF_PLUS) begin
      r = 8'd1;
    end else if (code == OFF_MINUS) begin
      r = 8'hFF;
    end
    return r;
  endfunction

  function automatic logic [SCOORD_W-1:0] abs_diff(input logic [SCOORD_W-1:0] a,
                                                   input logic [SCOORD_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== src/gse_front.sv =====
// ---------------------------------------------------------------------------
// Expander front end
// Accepts input words, classifies them and queues them for the back end.
// ---------------------------------------------------------------------------
module gse_front #(
  parameter int unsigned GRID_SIDE = gse_pkg::GRID_SIDE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [gse_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             clearing_i,
  output logic                             q_valid_o,
  output gse_pkg::cmd_t                    q_cmd_o,
  input  logic                             q_pop_i
);

  localparam logic [gse_pkg::SCOORD_W-1:0] SIDE = gse_pkg::SCOORD_W'(GRID_SIDE);

  gse_pkg::cmd_t cmd_in;
  gse_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push, in_store;

  assign in_store = ({2'b00, s_axis_tdata[5:0]} < SIDE) &&
                    ({2'b00, s_axis_tdata[11:6]} < SIDE) &&
                    ({2'b00, s_axis_tdata[17:12]} < SIDE);

  always_comb begin
    cmd_in.cx   = s_axis_tdata[5:0];
    cmd_in.cy   = s_axis_tdata[11:6];
    cmd_in.cz   = s_axis_tdata[17:12];
    cmd_in.occ  = s_axis_tdata[18];
    cmd_in.mask = s_axis_tdata[24:19];
    cmd_in.ax   = s_axis_tdata[30:25];
    cmd_in.ay   = s_axis_tdata[36:31];
    cmd_in.az   = s_axis_tdata[42:37];
    cmd_in.px   = s_axis_tdata[48:43];
    cmd_in.py   = s_axis_tdata[54:49];
    cmd_in.pz   = s_axis_tdata[60:55];
    // Writes that fall outside the store are kept as no-ops to stay in order.
    if (s_axis_tuser) begin
      cmd_in.op = gse_pkg::OP_EXPAND;
    end else if (in_store) begin
      cmd_in.op = gse_pkg::OP_WRITE;
    end else begin
      cmd_in.op = gse_pkg::OP_NOP;
    end
  end

  assign s_axis_tready = (cnt_q != 2'd2) && !clearing_i;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== src/gse_back.sv =====
// ---------------------------------------------------------------------------
// Expander back end
// Holds the voxel stores, clears them after reset and walks the move slots.
// ---------------------------------------------------------------------------
module gse_back #(
  parameter int unsigned GRID_SIDE = gse_pkg::GRID_SIDE_DEF,
  parameter int unsigned NUM_MOVES = gse_pkg::NUM_MOVES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gse_pkg::move_t                   cfg_move_i [gse_pkg::NUM_SLOTS],
  input  logic [gse_pkg::DIMS_W-1:0]       cfg_dims_i,
  input  logic                             q_valid_i,
  input  gse_pkg::cmd_t                    q_cmd_i,
  output logic                             q_pop_o,
  output logic                             clearing_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gse_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int unsigned CW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned AW    = 3 * CW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [gse_pkg::SCOORD_W-1:0] SIDE = gse_pkg::SCOORD_W'(GRID_SIDE);
  localparam logic [gse_pkg::SLOT_W-1:0] LAST_SLOT = gse_pkg::SLOT_W'(NUM_MOVES);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOVE,
    ST_EVAL
  } state_e;

  state_e                           state_q;
  logic [AW-1:0]                    clr_q;
  logic [gse_pkg::SLOT_W-1:0]       slot_q;
  gse_pkg::cmd_t                    cmd_q;
  logic [gse_pkg::SCOORD_W-1:0]     sx_q, sy_q, sz_q;
  logic                             inb_q;
  logic                             found_q;
  logic [gse_pkg::DIST_W-1:0]       bdist_q;
  logic [gse_pkg::SCOORD_W-1:0]     bx_q, by_q, bz_q;
  logic [gse_pkg::NEXT_ID_W-1:0]    next_id_q;
  logic                             out_valid_q;
  logic [gse_pkg::OUT_TDATA_W-1:0]  out_data_q;
  logic                             out_user_q, out_last_q;

  logic                             occ_mem   [DEPTH];
  logic                             known_mem [DEPTH];
  logic [gse_pkg::ID_W-1:0]         id_mem    [DEPTH];
  logic                             occ_rd_q, known_rd_q;
  logic [gse_pkg::ID_W-1:0]         id_rd_q;

  gse_pkg::move_t                   move_w;
  logic [gse_pkg::SCOORD_W-1:0]     rows, cols, hts;
  logic [gse_pkg::SCOORD_W-1:0]     sx_n, sy_n, sz_n;
  logic                             inb_n;
  logic [AW-1:0]                    rd_addr, ev_addr, wr_addr;
  logic                             occ_we, occ_wd, known_we, known_wd, id_we;
  logic                             is_free, better, take, alloc, more, go, pm;
  logic [gse_pkg::DIST_W-1:0]       man_dist;
  logic [gse_pkg::SCOORD_W-1:0]     bx_n, by_n, bz_n;
  logic [gse_pkg::ID_W-1:0]         res_id;
  logic [gse_pkg::COST_W-1:0]       res_cost;

  function automatic logic [gse_pkg::SCOORD_W-1:0] clip_dim(
      input logic [gse_pkg::DIM_W-1:0] d);
    logic [gse_pkg::SCOORD_W-1:0] e;
    e = {1'b0, d};
    return (e > SIDE) ? SIDE : e;
  endfunction

  assign rows = clip_dim(cfg_dims_i[6:0]);
  assign cols = clip_dim(cfg_dims_i[13:7]);
  assign hts  = clip_dim(cfg_dims_i[20:14]);

  assign move_w = (slot_q < gse_pkg::SLOT_W'(gse_pkg::NUM_SLOTS)) ?
                  cfg_move_i[slot_q] : '0;

  assign sx_n = {2'b00, cmd_q.cx} + gse_pkg::offset_of(move_w[1:0]);
  assign sy_n = {2'b00, cmd_q.cy} + gse_pkg::offset_of(move_w[3:2]);
  assign sz_n = {2'b00, cmd_q.cz} + gse_pkg::offset_of(move_w[5:4]);
  // A step below zero wraps to a large value and fails the bound check.
  assign inb_n = (sx_n < rows) && (sy_n < cols) && (sz_n < hts);

  assign rd_addr = {sx_n[CW-1:0], sy_n[CW-1:0], sz_n[CW-1:0]};
  assign ev_addr = {sx_q[CW-1:0], sy_q[CW-1:0], sz_q[CW-1:0]};

  assign go       = (state_q == ST_EVAL) && (!out_valid_q || m_axis_tready);
  assign is_free  = inb_q && !occ_rd_q;
  assign man_dist = gse_pkg::DIST_W'(gse_pkg::abs_diff(sx_q, {2'b00, cmd_q.ax})) +
                    gse_pkg::DIST_W'(gse_pkg::abs_diff(sy_q, {2'b00, cmd_q.ay})) +
                    gse_pkg::DIST_W'(gse_pkg::abs_diff(sz_q, {2'b00, cmd_q.az}));
  assign better   = is_free && (!found_q || (man_dist < bdist_q));
  assign take     = is_free && cmd_q.mask[slot_q];
  assign alloc    = take && !known_rd_q;
  assign bx_n     = better ? sx_q : bx_q;
  assign by_n     = better ? sy_q : by_q;
  assign bz_n     = better ? sz_q : bz_q;

  always_comb begin
    more = 1'b0;
    for (int j = 0; j < gse_pkg::NUM_SLOTS; j++) begin
      if ((gse_pkg::SLOT_W'(j) > slot_q) && (j < NUM_MOVES) &&
          cfg_move_i[j][gse_pkg::MV_EN_BIT]) begin
        more = 1'b1;
      end
    end
  end

  assign pm = !more && (found_q || is_free) &&
              (bx_n == {2'b00, cmd_q.px}) && (by_n == {2'b00, cmd_q.py}) &&
              (bz_n == {2'b00, cmd_q.pz});

  assign res_id   = take ? (known_rd_q ? id_rd_q : next_id_q[gse_pkg::ID_W-1:0]) : '0;
  assign res_cost = take ? move_w[gse_pkg::MV_COST_LO +: gse_pkg::COST_W] : '0;

  assign q_pop_o    = (state_q == ST_IDLE) && q_valid_i;
  assign clearing_o = (state_q == ST_CLEAR);

  always_comb begin
    wr_addr  = clr_q;
    occ_we   = 1'b0;
    occ_wd   = 1'b0;
    known_we = 1'b0;
    known_wd = 1'b0;
    id_we    = 1'b0;
    if (state_q == ST_CLEAR) begin
      occ_we   = 1'b1;
      known_we = 1'b1;
    end else if (q_pop_o && (q_cmd_i.op == gse_pkg::OP_WRITE)) begin
      wr_addr = {q_cmd_i.cx[CW-1:0], q_cmd_i.cy[CW-1:0], q_cmd_i.cz[CW-1:0]};
      occ_we  = 1'b1;
      occ_wd  = q_cmd_i.occ;
    end else if (go && alloc) begin
      wr_addr  = ev_addr;
      known_we = 1'b1;
      known_wd = 1'b1;
      id_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[wr_addr] <= occ_wd;
    end
    if (known_we) begin
      known_mem[wr_addr] <= known_wd;
    end
    if (id_we) begin
      id_mem[wr_addr] <= next_id_q[gse_pkg::ID_W-1:0];
    end
    occ_rd_q   <= occ_mem[rd_addr];
    known_rd_q <= known_mem[rd_addr];
    id_rd_q    <= id_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      slot_q      <= '0;
      found_q     <= 1'b0;
      next_id_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && !go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid_i && (q_cmd_i.op == gse_pkg::OP_EXPAND)) begin
            cmd_q   <= q_cmd_i;
            slot_q  <= '0;
            found_q <= 1'b0;
            state_q <= ST_MOVE;
          end
        end
        ST_MOVE: begin
          if (slot_q >= LAST_SLOT) begin
            state_q <= ST_IDLE;
          end else if (!move_w[gse_pkg::MV_EN_BIT]) begin
            slot_q <= slot_q + 1'b1;
          end else begin
            sx_q    <= sx_n;
            sy_q    <= sy_n;
            sz_q    <= sz_n;
            inb_q   <= inb_n;
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (go) begin
            if (better) begin
              bdist_q <= man_dist;
              bx_q    <= sx_q;
              by_q    <= sy_q;
              bz_q    <= sz_q;
            end
            found_q <= found_q || is_free;
            if (alloc) begin
              next_id_q <= next_id_q + 1'b1;
            end
            out_valid_q <= 1'b1;
            out_data_q  <= {2'b00, pm, res_cost, res_id, slot_q};
            out_user_q  <= take;
            out_last_q  <= !more;
            slot_q      <= slot_q + 1'b1;
            state_q     <= ST_MOVE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== src/grid_successor_expander_3d.sv =====
// ---------------------------------------------------------------------------
// 3D grid successor expander
// Voxel occupancy store with successor expansion, id allocation and a
// nearest-to-attractor search for a graph search engine.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake                  Payload
// s_axis   in   s_axis_tvalid/tready       tdata fields, tuser = action
// m_axis   out  m_axis_tvalid/tready       tdata fields, tuser = succ_valid, tlast
// cfg      in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// A write word is handled in the back end as it leaves the queue. An expand
// leaves the queue, then the back end steps past each disabled slot and takes
// each enabled slot through an address step and then a registered memory read
// and id update that waits while results stall; a final step ends the expand.
// After reset the voxel stores are cleared at one entry a cycle, all
// 2**(3*clog2(GRID_SIDE)) entries, while no word is taken on s_axis.
// A two-word queue lets the front take up to two words while results stall.
// ---------------------------------------------------------------------------
module grid_successor_expander_3d #(
  parameter int unsigned GRID_SIDE = gse_pkg::GRID_SIDE_DEF,
  parameter int unsigned NUM_MOVES = gse_pkg::NUM_MOVES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // cur_x, cur_y, cur_z, occupied, move_mask, attr_x, attr_y, attr_z,
  // pred_x, pred_y, pred_z, zero fill
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [gse_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tuser,   // action
  // move_index, succ_id, step_cost, pred_match, zero fill
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [gse_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tuser,   // succ_valid
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gse_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gse_pkg::MOVE_W-1:0]       cfg_data_i
);

  gse_pkg::move_t               move_q [gse_pkg::NUM_SLOTS];
  logic [gse_pkg::DIMS_W-1:0]   dims_q;
  logic                         q_valid, q_pop, clearing;
  gse_pkg::cmd_t                q_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gse_pkg::NUM_SLOTS; i++) begin
        move_q[i] <= '0;
      end
      dims_q <= gse_pkg::DIMS_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == gse_pkg::CFG_DIMS) begin
        dims_q <= cfg_data_i[gse_pkg::DIMS_W-1:0];
      end else if (cfg_index_i < gse_pkg::CFG_DIMS) begin
        move_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

  gse_front #(
    .GRID_SIDE(GRID_SIDE)
  ) u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .clearing_i (clearing),
    .q_valid_o  (q_valid),
    .q_cmd_o    (q_cmd),
    .q_pop_i    (q_pop)
  );

  gse_back #(
    .GRID_SIDE(GRID_SIDE),
    .NUM_MOVES(NUM_MOVES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_move_i (move_q),
    .cfg_dims_i (dims_q),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the 3D grid successor expander
// Drives occupancy writes and expand words into the block, keeps its own
// model of the voxel store, the id table and the move registers, and checks
// every result word field by field in order. Directed cases come first,
// then random phases under several move and grid settings, then a long
// result stall that backs the block up.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RUN_LIMIT  = 3000000;
  localparam int unsigned DRAIN_WAIT = 40;
  localparam int unsigned CELLS      = 262144;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_EXPAND = 1'b1;

  localparam logic [gse_pkg::CFG_IDX_W-1:0] CFG_MOVE_0 = 3'd0;

  localparam logic [1:0] OFF_NONE = 2'd0;
  localparam logic [1:0] OFF_ALT  = 2'd2;

  typedef struct {
    logic       action;
    logic [5:0] cx, cy, cz;
    logic       occ;
    logic [5:0] mask;
    logic [5:0] ax, ay, az;
    logic [5:0] px, py, pz;
  } voxel_word_t;

  typedef struct {
    logic [2:0]  slot;
    logic        valid;
    logic [17:0] id;
    logic [15:0] cost;
    logic        match;
    logic        last;
  } succ_result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_valid;
  logic                            s_ready;
  logic [gse_pkg::IN_TDATA_W-1:0]  s_data;
  logic                            s_user;
  logic                            m_valid;
  logic                            m_ready;
  logic [gse_pkg::OUT_TDATA_W-1:0] m_data;
  logic                            m_user;
  logic                            m_last;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [gse_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [gse_pkg::MOVE_W-1:0]      cfg_data;

  grid_successor_expander_3d i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // Model state.
  bit            occ_map [CELLS];
  bit            id_seen [CELLS];
  logic [17:0]   id_of   [CELLS];
  logic [18:0]   next_id_q;
  logic [22:0]   move_reg [6];
  logic [20:0]   dims_reg;
  succ_result_t  succ_q [$];

  int unsigned cycles;
  int unsigned errors;
  int unsigned n_expands, n_writes, n_results, n_valid, n_match;
  int          rx_hold;
  bit          tx_no_idle, rx_no_idle;

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, succ_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int step_of(logic [1:0] code);
    if (code == gse_pkg::OFF_PLUS) return 1;
    if (code == gse_pkg::OFF_MINUS) return -1;
    return 0;
  endfunction

  function automatic int dim_limit(logic [6:0] d);
    return (d > 7'd64) ? 64 : int'(d);
  endfunction

  function automatic int abs_int(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void predict_word(voxel_word_t w);
    succ_result_t outs [$];
    succ_result_t e;
    logic [22:0]  m;
    int rows, cols, hts, sx, sy, sz, d, best_d, bx, by, bz, idx;
    bit found, is_free;
    if (w.action == ACT_WRITE) begin
      occ_map[{w.cx, w.cy, w.cz}] = w.occ;
      n_writes++;
      return;
    end
    n_expands++;
    rows = dim_limit(dims_reg[6:0]);
    cols = dim_limit(dims_reg[13:7]);
    hts  = dim_limit(dims_reg[20:14]);
    found = 1'b0;
    best_d = 0; bx = 0; by = 0; bz = 0;
    for (int s = 0; s < 6; s++) begin
      m = move_reg[s];
      if (!m[gse_pkg::MV_EN_BIT]) continue;
      sx = int'(w.cx) + step_of(m[1:0]);
      sy = int'(w.cy) + step_of(m[3:2]);
      sz = int'(w.cz) + step_of(m[5:4]);
      e = '{slot: 3'(s), valid: 1'b0, id: '0, cost: '0, match: 1'b0, last: 1'b0};
      is_free = 1'b0;
      idx = 0;
      if (sx >= 0 && sx < rows && sy >= 0 && sy < cols && sz >= 0 && sz < hts) begin
        idx = (sx * 64 + sy) * 64 + sz;
        is_free = !occ_map[idx];
      end
      if (is_free) begin
        d = abs_int(sx - int'(w.ax)) + abs_int(sy - int'(w.ay)) + abs_int(sz - int'(w.az));
        if (!found || d < best_d) begin
          found = 1'b1;
          best_d = d;
          bx = sx; by = sy; bz = sz;
        end
        if (w.mask[s]) begin
          if (!id_seen[idx]) begin
            id_seen[idx] = 1'b1;
            id_of[idx] = next_id_q[17:0];
            next_id_q = next_id_q + 1'b1;
          end
          e.valid = 1'b1;
          e.id = id_of[idx];
          e.cost = m[21:6];
        end
      end
      outs.insert(outs.size(), e);
    end
    if (outs.size() > 0) begin
      outs[$].last = 1'b1;
      outs[$].match = found && bx == int'(w.px) && by == int'(w.py) && bz == int'(w.pz);
      if (outs[$].match) n_match++;
    end
    foreach (outs[i]) succ_q.insert(succ_q.size(), outs[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint exp_v, longint act_v);
    errors++;
    if (errors <= 10)
      $display("Mismatch in %s at cycle %0d: expected %0h, got %0h", what, cycles, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    succ_result_t e;
    if (rst_ni && m_valid && m_ready) begin
      n_results++;
      if (m_user) n_valid++;
      if (succ_q.size() == 0) begin
        report_mismatch("unexpected word", 0, m_data);
      end else begin
        e = succ_q.pop_front();
        if (m_data[2:0] != e.slot) report_mismatch("move_index", e.slot, m_data[2:0]);
        if (m_user != e.valid) report_mismatch("succ_valid", e.valid, m_user);
        if (m_data[20:3] != e.id) report_mismatch("succ_id", e.id, m_data[20:3]);
        if (m_data[36:21] != e.cost) report_mismatch("step_cost", e.cost, m_data[36:21]);
        if (m_data[37] != e.match) report_mismatch("pred_match", e.match, m_data[37]);
        if (m_last != e.last) report_mismatch("last", e.last, m_last);
      end
    end
  end

  // A forced hold from the stall test overrides the random stalls.
  always @(negedge clk_i) begin
    int stall_left;
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_ready <= 1'b0;
    end else if (rx_no_idle) begin
      stall_left = 0;
      m_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      m_ready <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 2);
      m_ready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (tx_no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(voxel_word_t w);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_user  <= w.action;
    s_data  <= {3'b0, w.pz, w.py, w.px, w.az, w.ay, w.ax, w.mask, w.occ, w.cz, w.cy, w.cx};
    do @(posedge clk_i); while (!s_ready);
    predict_word(w);
  endtask

  task automatic write_reg(logic [gse_pkg::CFG_IDX_W-1:0] idx, logic [gse_pkg::MOVE_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == gse_pkg::CFG_DIMS) dims_reg = val[20:0];
    else move_reg[idx] = val;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Writes give no result, so leave the back end time to finish an expand.
  task automatic wait_idle();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (succ_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [22:0] make_move(logic [1:0] dx, logic [1:0] dy, logic [1:0] dz,
                                            logic [15:0] cost, logic en);
    return {en, cost, dz, dy, dx};
  endfunction

  function automatic voxel_word_t make_expand(int x, int y, int z, logic [5:0] mask,
                                              int ax, int ay, int az, int px, int py, int pz);
    return '{action: ACT_EXPAND, cx: 6'(x), cy: 6'(y), cz: 6'(z), occ: 1'b0, mask: mask,
             ax: 6'(ax), ay: 6'(ay), az: 6'(az), px: 6'(px), py: 6'(py), pz: 6'(pz)};
  endfunction

  function automatic voxel_word_t make_write(int x, int y, int z, logic occ);
    voxel_word_t w;
    w = make_expand(x, y, z, '0, 0, 0, 0, 0, 0, 0);
    w.action = ACT_WRITE;
    w.occ = occ;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // With every slot disabled an expand returns nothing.
    send_word(make_expand(3, 3, 3, 6'h3F, 0, 0, 0, 0, 0, 0));
    wait_idle();
    write_reg(CFG_MOVE_0 + 3'd0,
              make_move(gse_pkg::OFF_PLUS, OFF_NONE, OFF_NONE, 16'h0100, 1'b1));
    write_reg(CFG_MOVE_0 + 3'd1,
              make_move(gse_pkg::OFF_MINUS, OFF_NONE, OFF_NONE, 16'hFFFF, 1'b1));
    write_reg(CFG_MOVE_0 + 3'd2,
              make_move(OFF_NONE, gse_pkg::OFF_PLUS, OFF_NONE, 16'h0000, 1'b1));
    write_reg(CFG_MOVE_0 + 3'd3,
              make_move(OFF_NONE, gse_pkg::OFF_MINUS, gse_pkg::OFF_MINUS, 16'h0180, 1'b1));
    write_reg(CFG_MOVE_0 + 3'd4,
              make_move(OFF_NONE, OFF_NONE, gse_pkg::OFF_PLUS, 16'h7FFF, 1'b1));
    write_reg(CFG_MOVE_0 + 3'd5, make_move(OFF_ALT, OFF_ALT, OFF_ALT, 16'h0080, 1'b1));
    send_word(make_expand(0, 0, 0, 6'h3F, 5, 0, 0, 1, 0, 0));
    send_word(make_expand(63, 63, 63, 6'h3F, 63, 63, 63, 63, 63, 63));
    send_word(make_write(1, 0, 0, 1'b1));
    send_word(make_write(0, 1, 0, 1'b1));
    send_word(make_expand(0, 0, 0, 6'h15, 0, 0, 9, 0, 0, 1));
    // Slots 0, 1, 2 and 4 tie and the lower one wins; slot 5 stays on the voxel and is nearer.
    send_word(make_expand(10, 10, 10, 6'h3F, 10, 10, 10, 11, 10, 10));
    send_word(make_expand(10, 10, 10, 6'h00, 10, 10, 10, 10, 10, 10));
    send_word(make_write(1, 0, 0, 1'b0));
    send_word(make_write(63, 63, 63, 1'b1));
    send_word(make_expand(63, 63, 62, 6'h3F, 0, 0, 0, 62, 63, 62));
    // Surround a voxel so that no successor is free.
    send_word(make_write(5, 6, 5, 1'b1));
    send_word(make_write(5, 5, 6, 1'b1));
    send_word(make_write(5, 5, 5, 1'b1));
    send_word(make_write(6, 5, 5, 1'b1));
    send_word(make_write(4, 5, 5, 1'b1));
    send_word(make_write(5, 4, 4, 1'b1));
    send_word(make_expand(5, 5, 5, 6'h3F, 5, 5, 5, 5, 5, 5));
    wait_idle();
    write_reg(gse_pkg::CFG_DIMS, 23'h1FFFFF);
    send_word(make_expand(63, 62, 40, 6'h3F, 0, 63, 0, 62, 62, 40));
    wait_idle();
    write_reg(gse_pkg::CFG_DIMS, {2'b0, 7'd64, 7'd64, 7'd0});
    send_word(make_expand(0, 0, 0, 6'h3F, 0, 0, 0, 0, 0, 0));
    wait_idle();
  endtask

  function automatic int pick_coord(logic [6:0] dim);
    int hi;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    hi = (dim > 7'd62) ? 63 : int'(dim) + 1;
    return $urandom_range(0, hi);
  endfunction

  function automatic int near(int c);
    return (c + $urandom_range(0, 6) - 3) & 63;
  endfunction

  task automatic run_random_phase(int n_words, logic [20:0] dims, bit axis_moves);
    voxel_word_t w;
    int slot;
    logic [22:0] m;
    wait_idle();
    write_reg(gse_pkg::CFG_DIMS, {2'b0, dims});
    for (int s = 0; s < 6; s++) begin
      if (axis_moves)
        m = make_move((s == 0) ? gse_pkg::OFF_PLUS : (s == 1) ? gse_pkg::OFF_MINUS : OFF_NONE,
                      (s == 2) ? gse_pkg::OFF_PLUS : (s == 3) ? gse_pkg::OFF_MINUS : OFF_NONE,
                      (s == 4) ? gse_pkg::OFF_PLUS : (s == 5) ? gse_pkg::OFF_MINUS : OFF_NONE,
                      16'($urandom), $urandom_range(0, 9) != 0);
      else
        m = make_move(2'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
                      $urandom_range(0, 5) != 0);
      write_reg(CFG_MOVE_0 + 3'(s), m);
    end
    for (int i = 0; i < n_words; i++) begin
      if (i % 40 == 0) begin
        tx_no_idle = ($urandom_range(0, 3) == 0);
        rx_no_idle = ($urandom_range(0, 3) == 0);
      end
      w.cx = 6'(pick_coord(dims[6:0]));
      w.cy = 6'(pick_coord(dims[13:7]));
      w.cz = 6'(pick_coord(dims[20:14]));
      w.occ = 1'($urandom_range(0, 1));
      w.mask = ($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'h3F;
      w.action = ($urandom_range(0, 99) < 30) ? ACT_WRITE : ACT_EXPAND;
      if ($urandom_range(0, 4) == 0) begin
        {w.ax, w.ay, w.az} = 18'($urandom);
      end else begin
        w.ax = 6'(near(w.cx)); w.ay = 6'(near(w.cy)); w.az = 6'(near(w.cz));
      end
      // Mostly aim the predecessor at one of the successors.
      if ($urandom_range(0, 9) < 6) begin
        slot = $urandom_range(0, 5);
        m = move_reg[slot];
        w.px = w.cx + 6'(step_of(m[1:0]));
        w.py = w.cy + 6'(step_of(m[3:2]));
        w.pz = w.cz + 6'(step_of(m[5:4]));
      end else begin
        {w.px, w.py, w.pz} = 18'($urandom);
      end
      send_word(w);
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  task automatic test_random();
    run_random_phase(110, {7'd8, 7'd8, 7'd8}, 1'b1);
    run_random_phase(110, {7'd64, 7'd64, 7'd64}, 1'b0);
    run_random_phase(90, {7'd127, 7'd5, 7'd3}, 1'b0);
    run_random_phase(90, {7'd2, 7'd0, 7'd9}, 1'b1);
    run_random_phase(100, {7'd6, 7'd7, 7'd65}, 1'b0);
  endtask

  task automatic test_result_stall();
    wait_idle();
    for (int s = 0; s < 6; s++)
      write_reg(CFG_MOVE_0 + 3'(s), make_move(2'(s), 2'(s + 1), 2'(s + 2), 16'(s * 77), 1'b1));
    write_reg(gse_pkg::CFG_DIMS, {2'b0, 7'd16, 7'd16, 7'd16});
    rx_hold = 400;
    tx_no_idle = 1'b1;
    for (int i = 0; i < 20; i++)
      send_word(make_expand($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                            6'h3F, 8, 8, 8, 8, 8, 8));
    tx_no_idle = 1'b0;
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_valid = 1'b0; s_data = '0; s_user = 1'b0;
    m_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    cycles = 0; errors = 0; rx_hold = 0;
    tx_no_idle = 1'b0; rx_no_idle = 1'b0;
    n_expands = 0; n_writes = 0; n_results = 0; n_valid = 0; n_match = 0;
    next_id_q = '0;
    dims_reg = gse_pkg::DIMS_RESET;
    foreach (move_reg[i]) move_reg[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    test_result_stall();
    wait_idle();
    $display("Covered %0d expands and %0d occupancy writes; %0d result words checked,",
             n_expands, n_writes, n_results);
    $display("%0d valid successors, %0d predecessor hits, %0d ids handed out, %0d mismatches.",
             n_valid, n_match, next_id_q, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gse_pkg.sv
src/gse_front.sv
src/gse_back.sv
src/grid_successor_expander_3d.sv
verif/tb_top.sv
